// ===== src/iqfc_pkg.sv =====
package iqfc_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int CHAN_W     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int RATE_W     = 24;
    localparam int INDEX_W    = 10;
    localparam int SQ_W       = 31;
    localparam int MAG_W      = 32;

    // Configuration registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int LISTEN_W   = 3;
    localparam int FLEN_W     = 11;
    localparam int LEVEL_W    = 31;
    localparam int FRAC_W     = 16;
    localparam int LIMIT_W    = FRAC_W + FLEN_W;

    localparam int MIN_FRAME         = 64;
    localparam int FRAME_LEN_DEFAULT = 1024;

    localparam logic [LISTEN_W-1:0] LISTEN_RESET        = 3'd1;
    localparam logic [LEVEL_W-1:0]  SAT_LEVEL_RESET     = 31'd1071595414;
    localparam logic [FRAC_W-1:0]   CLIP_FRACTION_RESET = 16'd655;

    // Stream packing, lowest bit first
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_TUSER_W = 2;

    localparam int IN_CHAN_LSB  = 0;
    localparam int IN_I_LSB     = IN_CHAN_LSB + CHAN_W;
    localparam int IN_Q_LSB     = IN_I_LSB + SAMPLE_W;
    localparam int IN_RATE_LSB  = IN_Q_LSB + SAMPLE_W;
    localparam int IN_USED_W    = IN_RATE_LSB + RATE_W;

    localparam int OUT_I_LSB     = 0;
    localparam int OUT_Q_LSB     = OUT_I_LSB + SAMPLE_W;
    localparam int OUT_INDEX_LSB = OUT_Q_LSB + SAMPLE_W;
    localparam int OUT_RATE_LSB  = OUT_INDEX_LSB + INDEX_W;
    localparam int OUT_USED_W    = OUT_RATE_LSB + RATE_W;

    localparam int TUSER_CLIPPED = 0;
    localparam int TUSER_DROPPED = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE     = 2'd0,
        CMD_GATE_OPEN  = 2'd1,
        CMD_GATE_CLOSE = 2'd2,
        CMD_RATE       = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE           = 3'd0,
        REG_LISTEN_CHANNEL   = 3'd1,
        REG_FRAME_LENGTH     = 3'd2,
        REG_SATURATION_LEVEL = 3'd3,
        REG_CLIP_FRACTION    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_cmd                       cmd;
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] i_sample;
        logic signed [SAMPLE_W-1:0] q_sample;
        logic [RATE_W-1:0]          rate_hz;
    } t_item;

    typedef struct packed {
        logic                 enable;
        logic [LISTEN_W-1:0]  listen_channel;
        logic [FLEN_W-1:0]    frame_length;
        logic [LEVEL_W-1:0]   saturation_level;
        logic [LIMIT_W-1:0]   clip_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] i_out;
        logic signed [SAMPLE_W-1:0] q_out;
        logic [INDEX_W-1:0]         sample_index;
        logic                       frame_last;
        logic                       clipped;
        logic                       partial_dropped;
        logic [RATE_W-1:0]          frame_rate_hz;
    } t_result;

endpackage

// ===== src/iqfc_cfg.sv =====
module iqfc_cfg #(
    parameter int FRAME_MAX    = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [iqfc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [iqfc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output iqfc_pkg::t_cfg                   o_cfg,
    output logic                             o_clear
);
    import iqfc_pkg::*;

    localparam int FLEN_RESET_INT =
        (FRAME_MAX < FRAME_LEN_DEFAULT) ? FRAME_MAX : FRAME_LEN_DEFAULT;
    localparam logic [FLEN_W-1:0] FLEN_RESET = FLEN_W'(FLEN_RESET_INT);

    logic                r_enable;
    logic [LISTEN_W-1:0] r_listen;
    logic [FLEN_W-1:0]   r_frame_len;
    logic [LEVEL_W-1:0]  r_sat_level;
    logic [FRAC_W-1:0]   r_clip_frac;
    logic [LIMIT_W-1:0]  r_clip_limit;

    logic [LISTEN_W-1:0] listen_sat;
    logic [FLEN_W-1:0]   flen_sat;

    // Saturate channel and frame length writes into their legal ranges
    always_comb begin
        listen_sat = i_cfg_data[LISTEN_W-1:0];
        if (listen_sat == '0) begin
            listen_sat = LISTEN_W'(1);
        end
        if (int'(listen_sat) > MAX_CHANNELS) begin
            listen_sat = LISTEN_W'(MAX_CHANNELS);
        end
        flen_sat = i_cfg_data[FLEN_W-1:0];
        if (int'(flen_sat) < MIN_FRAME) begin
            flen_sat = FLEN_W'(MIN_FRAME);
        end
        if (int'(flen_sat) > FRAME_MAX) begin
            flen_sat = FLEN_W'(FRAME_MAX);
        end
    end

    assign o_clear = i_cfg_we && (i_cfg_index == REG_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_listen    <= LISTEN_RESET;
            r_frame_len <= FLEN_RESET;
            r_sat_level <= SAT_LEVEL_RESET;
            r_clip_frac <= CLIP_FRACTION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLE:           r_enable    <= i_cfg_data[0];
                REG_LISTEN_CHANNEL:   r_listen    <= listen_sat;
                REG_FRAME_LENGTH:     r_frame_len <= flen_sat;
                REG_SATURATION_LEVEL: r_sat_level <= i_cfg_data[LEVEL_W-1:0];
                REG_CLIP_FRACTION:    r_clip_frac <= i_cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // Clip threshold in sample units times 2^16, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_clip_limit <= LIMIT_W'(r_clip_frac) * LIMIT_W'(r_frame_len);
    end

    assign o_cfg.enable           = r_enable;
    assign o_cfg.listen_channel   = r_listen;
    assign o_cfg.frame_length     = r_frame_len;
    assign o_cfg.saturation_level = r_sat_level;
    assign o_cfg.clip_limit       = r_clip_limit;

endmodule

// ===== src/iqfc_mag.sv =====
module iqfc_mag (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_valid,
    input  iqfc_pkg::t_item             i_item,
    output logic                        o_valid,
    output iqfc_pkg::t_item             o_item,
    output logic [iqfc_pkg::SQ_W-1:0]   o_i_sq,
    output logic [iqfc_pkg::SQ_W-1:0]   o_q_sq
);
    import iqfc_pkg::*;

    logic              r_valid;
    t_item             r_item;
    logic [SQ_W-1:0]   r_i_sq;
    logic [SQ_W-1:0]   r_q_sq;
    logic signed [2*SAMPLE_W-1:0] i_prod;
    logic signed [2*SAMPLE_W-1:0] q_prod;

    assign i_prod = $signed(i_item.i_sample) * $signed(i_item.i_sample);
    assign q_prod = $signed(i_item.q_sample) * $signed(i_item.q_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    // Squares are never negative and top out at 2^30
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_item <= i_item;
            r_i_sq <= i_prod[SQ_W-1:0];
            r_q_sq <= q_prod[SQ_W-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_i_sq  = r_i_sq;
    assign o_q_sq  = r_q_sq;

endmodule

// ===== src/iqfc_frame.sv =====
module iqfc_frame #(
    parameter int FRAME_MAX = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_clear,
    input  iqfc_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    input  iqfc_pkg::t_item             i_item,
    input  logic [iqfc_pkg::SQ_W-1:0]   i_i_sq,
    input  logic [iqfc_pkg::SQ_W-1:0]   i_q_sq,
    output logic                        o_valid,
    output iqfc_pkg::t_result           o_res
);
    import iqfc_pkg::*;

    localparam int CNT_W = $clog2(FRAME_MAX + 1);

    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_sat;
    logic              r_gate;
    logic [RATE_W-1:0] r_rate;
    logic              r_drop;
    logic              r_out_valid;
    t_result           r_res;

    logic [CNT_W-1:0]  n_fill;
    logic [CNT_W-1:0]  n_sat;
    logic              n_gate;
    logic [RATE_W-1:0] n_rate;
    logic              n_drop;
    logic              n_out_valid;
    t_result           n_res;

    logic              want_open;
    logic              chan_match;
    logic              rate_ok;
    logic [MAG_W-1:0]  mag;
    logic              hit;
    logic [CNT_W-1:0]  fill_d;
    logic [CNT_W-1:0]  sat_d;
    logic              drop_d;
    logic [CNT_W-1:0]  fill_n;
    logic [CNT_W-1:0]  sat_n;
    logic              mark;
    logic              last;
    logic              clip;

    assign want_open  = (i_item.cmd == CMD_GATE_OPEN);
    assign chan_match = (i_item.channel == CHAN_W'(i_cfg.listen_channel));
    assign rate_ok    = (i_item.rate_hz != '0);
    assign mag        = MAG_W'(i_i_sq) + MAG_W'(i_q_sq);
    assign hit        = (mag >= MAG_W'(i_cfg.saturation_level));

    always_comb begin
        n_fill      = r_fill;
        n_sat       = r_sat;
        n_gate      = r_gate;
        n_rate      = r_rate;
        n_drop      = r_drop;
        n_out_valid = 1'b0;
        n_res       = r_res;
        fill_d      = r_fill;
        sat_d       = r_sat;
        drop_d      = r_drop;
        fill_n      = '0;
        sat_n       = '0;
        mark        = 1'b0;
        last        = 1'b0;
        clip        = 1'b0;
        if (i_valid) begin
            case (i_item.cmd)
                CMD_GATE_OPEN, CMD_GATE_CLOSE: begin
                    if (want_open != r_gate) begin
                        n_gate = want_open;
                        if (r_fill != '0) begin
                            n_drop = 1'b1;
                        end
                        n_fill = '0;
                        n_sat  = '0;
                    end
                end
                CMD_RATE: begin
                    if (chan_match && rate_ok) begin
                        n_rate = i_item.rate_hz;
                    end
                end
                CMD_SAMPLE: begin
                    if (i_cfg.enable && r_gate && chan_match && rate_ok) begin
                        // Drop the partial frame on a rate change
                        if (r_rate != '0 && r_rate != i_item.rate_hz) begin
                            if (r_fill != '0) begin
                                drop_d = 1'b1;
                            end
                            fill_d = '0;
                            sat_d  = '0;
                        end
                        n_rate = i_item.rate_hz;
                        sat_n  = sat_d + CNT_W'(hit);
                        fill_n = fill_d + CNT_W'(1);
                        mark   = (fill_d == '0) && drop_d;
                        n_drop = drop_d && !mark;
                        last   = (32'(fill_n) >= 32'(i_cfg.frame_length));
                        clip   = last &&
                                 (64'({sat_n, 16'b0}) > 64'(i_cfg.clip_limit));
                        n_fill = last ? '0 : fill_n;
                        n_sat  = last ? '0 : sat_n;
                        n_out_valid           = 1'b1;
                        n_res.i_out           = i_item.i_sample;
                        n_res.q_out           = i_item.q_sample;
                        n_res.sample_index    = INDEX_W'(fill_d);
                        n_res.frame_last      = last;
                        n_res.clipped         = clip;
                        n_res.partial_dropped = mark;
                        n_res.frame_rate_hz   = i_item.rate_hz;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_sat       <= '0;
            r_gate      <= 1'b0;
            r_rate      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_clear) begin
            r_fill <= '0;
            r_sat  <= '0;
            r_gate <= 1'b0;
            r_rate <= '0;
            r_drop <= 1'b0;
        end else if (i_advance) begin
            r_fill      <= n_fill;
            r_sat       <= n_sat;
            r_gate      <= n_gate;
            r_rate      <= n_rate;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

// ===== src/iq_frame_capture_clip_detect.sv =====
// IQ frame capture with clip detection.
//
// Feed commands on the s_axis side: tuser selects sample, gate open, gate
// close or rate report; tdata carries channel, I, Q and rate. Accepted
// samples leave on the m_axis side one for one, each tagged with its index
// in the frame; tlast marks the last sample of a frame, and tuser flags a
// clipped frame (on tlast) or a discarded partial frame (on the next first
// sample). Gate and rate commands produce no output.
//
// A request goes from input to output valid through the input register, the
// squaring register, then frame counting into the output register.
// Throughput is one request per cycle; the output register is the only
// place a stall is absorbed, and s_axis_tready drops only while a result
// waits there and m_axis_tready is low, which freezes the whole pipe.
//
// Reset empties the pipe, closes the gate, clears counts and stored rate,
// and loads the register defaults. Write registers through i_cfg_* only
// while the pipe is empty; a write to the enable register also clears
// counts, gate and stored rate.
module iq_frame_capture_clip_detect #(
    parameter int FRAME_MAX    = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // channel[3:0], i_sample[19:4], q_sample[35:20], rate_hz[59:36], zero pad
    input  logic [iqfc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd[1:0]
    input  logic [iqfc_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // i_out[15:0], q_out[31:16], sample_index[41:32], frame_rate_hz[65:42], zero pad
    output logic [iqfc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // clipped[0], partial_dropped[1]
    output logic [iqfc_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [iqfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iqfc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import iqfc_pkg::*;

    t_cfg            cfg;
    logic            cfg_clear;
    logic            advance;
    t_item           in_item;
    logic            r_in_valid;
    t_item           r_in;
    logic            mag_valid;
    t_item           mag_item;
    logic [SQ_W-1:0] mag_i_sq;
    logic [SQ_W-1:0] mag_q_sq;
    logic            res_valid;
    t_result         res;

    // Advance the whole pipe unless a result is held at the output
    assign advance       = !res_valid || m_axis_tready;
    assign s_axis_tready = advance;

    // Unpack the request
    assign in_item.cmd      = t_cmd'(s_axis_tuser);
    assign in_item.channel  = s_axis_tdata[IN_CHAN_LSB +: CHAN_W];
    assign in_item.i_sample = s_axis_tdata[IN_I_LSB +: SAMPLE_W];
    assign in_item.q_sample = s_axis_tdata[IN_Q_LSB +: SAMPLE_W];
    assign in_item.rate_hz  = s_axis_tdata[IN_RATE_LSB +: RATE_W];

    iqfc_cfg #(
        .FRAME_MAX    (FRAME_MAX),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_clear     (cfg_clear)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in <= in_item;
        end
    end

    iqfc_mag u_mag (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (r_in_valid),
        .i_item    (r_in),
        .o_valid   (mag_valid),
        .o_item    (mag_item),
        .o_i_sq    (mag_i_sq),
        .o_q_sq    (mag_q_sq)
    );

    iqfc_frame #(
        .FRAME_MAX (FRAME_MAX)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_clear   (cfg_clear),
        .i_cfg     (cfg),
        .i_valid   (mag_valid),
        .i_item    (mag_item),
        .i_i_sq    (mag_i_sq),
        .i_q_sq    (mag_q_sq),
        .o_valid   (res_valid),
        .o_res     (res)
    );

    // Pack the result
    assign m_axis_tvalid = res_valid;
    assign m_axis_tlast  = res.frame_last;
    assign m_axis_tuser  = {res.partial_dropped, res.clipped};
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                            res.frame_rate_hz, res.sample_index,
                            res.q_out, res.i_out};

`ifndef SYNTHESIS
    // A dropped-frame mark only opens a frame
    a_drop_on_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[TUSER_DROPPED]
            |-> m_axis_tdata[OUT_INDEX_LSB +: INDEX_W] == '0)
        else $error("partial_dropped on a sample that does not open a frame");

    // A clip decision is only made on the closing sample
    a_clip_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[TUSER_CLIPPED] |-> m_axis_tlast)
        else $error("clipped flag outside the last sample of a frame");

    // A result held while the receiver stalls must stay valid
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result lost while the receiver stalled");
`endif

endmodule
